@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define CNV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checks that a property holds in the cycle after a condition.
`define CNV_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ hw/rtl/cnv_pkg.sv @@
// Shared constants and types of the 3x3 convolution filter.
`default_nettype none
package cnv_pkg;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int PIX_W      = 8;
   localparam int TAP_W      = 5;
   localparam int NTAPS      = 9;
   localparam int TAPS_W     = TAP_W * NTAPS;
   localparam int CFG_DIM_W  = 11;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
   localparam int WD_W       = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ?
                               $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
   localparam int HD_W       = ($clog2(MAX_HEIGHT + 2) > CFG_DIM_W) ?
                               $clog2(MAX_HEIGHT + 2) : CFG_DIM_W;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 64;

   localparam logic [1:0] REG_TAPS   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [TAPS_W-1:0]    TAPS_RESET = 45'd1134979744801;
   localparam logic [CFG_DIM_W-1:0] DIM_RESET  = 11'd256;

   typedef logic [NTAPS-1:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic             done;
      logic [PIX_W-1:0] result;
   } norm_sts_type;
endpackage
`default_nettype wire

@@ hw/rtl/cnv_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module cnv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ hw/rtl/cnv_norm.sv @@
// Multiply-accumulate over the window and bit-serial normalizing divider.
`default_nettype none
module cnv_norm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  cnv_pkg::window_type       window,
   input  logic [cnv_pkg::TAPS_W-1:0] taps,
   output cnv_pkg::norm_sts_type     sts
);
   import cnv_pkg::*;

   localparam int IDX_W = $clog2(NTAPS);
   localparam int SUM_W = 17;
   localparam int MAG_W = 8;
   localparam int NUM_W = 26;
   localparam int REM_W = 17;

   typedef enum logic [2:0] {N_IDLE, N_MAC, N_PREP, N_SCALE, N_DIV} nstate_type;

   nstate_type               nstate_ff, nstate_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [MAG_W-1:0]         pos_ff, pos_in;
   logic [MAG_W-1:0]         neg_ff, neg_in;
   logic                     has_neg_ff, has_neg_in;
   logic signed [SUM_W:0]    num_ff, num_in;
   logic [MAG_W:0]           den_ff, den_in;
   logic                     zero_den_ff, zero_den_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [REM_W-1:0]         dsh_ff, dsh_in;
   logic [PIX_W-1:0]         q_ff, q_in;
   logic [PIX_W-1:0]         result_ff, result_in;
   logic                     done_ff, done_in;

   logic [TAP_W-1:0]         tap;
   logic [TAP_W:0]           tap_mag;
   logic signed [TAP_W+PIX_W:0] prod;
   logic [MAG_W-1:0]         m_val;
   logic [NUM_W-1:0]         num_abs;
   logic [NUM_W-1:0]         scaled;
   logic [NUM_W-1:0]         limit;
   logic                     qbit;

   always_comb begin
      tap      = taps[idx_ff * TAP_W +: TAP_W];
      tap_mag  = tap[TAP_W-1] ? ((TAP_W+1)'(1 << TAP_W) - {1'b0, tap}) : {1'b0, tap};
      prod     = $signed({tap[TAP_W-1], tap}) * $signed({1'b0, window[idx_ff]});
      m_val    = (has_neg_ff && (neg_ff > pos_ff)) ? neg_ff : pos_ff;
      num_abs  = NUM_W'(unsigned'(num_ff));
      scaled   = has_neg_ff ? ((num_abs << 8) - num_abs) : num_abs;
      limit    = NUM_W'(den_ff) << 8;
      qbit     = (rem_ff >= dsh_ff);

      nstate_in   = nstate_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      pos_in      = pos_ff;
      neg_in      = neg_ff;
      has_neg_in  = has_neg_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      zero_den_in = zero_den_ff;
      rem_in      = rem_ff;
      dsh_in      = dsh_ff;
      q_in        = q_ff;
      result_in   = result_ff;
      done_in     = 1'b0;

      case (nstate_ff)
         N_IDLE: begin
            if (start) begin
               idx_in     = '0;
               sum_in     = '0;
               pos_in     = '0;
               neg_in     = '0;
               has_neg_in = 1'b0;
               nstate_in  = N_MAC;
            end
         end
         N_MAC: begin
            sum_in = sum_ff + SUM_W'(prod);
            if (tap[TAP_W-1]) begin
               neg_in     = neg_ff + MAG_W'(tap_mag);
               has_neg_in = 1'b1;
            end else begin
               pos_in = pos_ff + MAG_W'(tap_mag);
            end
            if (idx_ff == IDX_W'(NTAPS - 1)) begin
               nstate_in = N_PREP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         N_PREP: begin
            if (has_neg_ff) begin
               num_in = (SUM_W+1)'(sum_ff) + $signed({2'b00, m_val});
               den_in = {m_val, 1'b0};
            end else begin
               num_in = (SUM_W+1)'(sum_ff);
               den_in = {1'b0, pos_ff};
            end
            zero_den_in = !has_neg_ff && (pos_ff == '0);
            nstate_in   = N_SCALE;
         end
         N_SCALE: begin
            nstate_in = N_IDLE;
            if (zero_den_ff) begin
               done_in = 1'b1;
               if (num_ff < 0) begin
                  result_in = '0;
               end else if (num_ff > (SUM_W+1)'(255)) begin
                  result_in = '1;
               end else begin
                  result_in = num_ff[PIX_W-1:0];
               end
            end else if (num_ff <= 0) begin
               done_in   = 1'b1;
               result_in = '0;
            end else if (scaled >= limit) begin
               done_in   = 1'b1;
               result_in = '1;
            end else begin
               rem_in    = scaled[REM_W-1:0];
               dsh_in    = REM_W'(den_ff) << (PIX_W - 1);
               q_in      = '0;
               idx_in    = IDX_W'(PIX_W - 1);
               nstate_in = N_DIV;
            end
         end
         N_DIV: begin
            if (qbit) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in = dsh_ff >> 1;
            q_in   = {q_ff[PIX_W-2:0], qbit};
            if (idx_ff == '0) begin
               result_in = {q_ff[PIX_W-2:0], qbit};
               done_in   = 1'b1;
               nstate_in = N_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: nstate_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nstate_ff <= N_IDLE;
         done_ff   <= 1'b0;
      end else begin
         nstate_ff <= nstate_in;
         done_ff   <= done_in;
      end
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      pos_ff      <= pos_in;
      neg_ff      <= neg_in;
      has_neg_ff  <= has_neg_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      zero_den_ff <= zero_den_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      q_ff        <= q_in;
      result_ff   <= result_in;
   end

   assign sts.done   = done_ff;
   assign sts.result = result_ff;
endmodule
`default_nettype wire

@@ hw/rtl/conv3x3_normalized_filter.sv @@
// Top level of the 3x3 normalized convolution filter.
// Pixels arrive in raster order, one request at a time; two line RAMs hold the
// previous rows and a 3x3 register window holds the neighborhood. A result for a
// position leaves width+1 requests after its pixel, and flush requests after the
// last pixel drain the frame. A request with no result passes read only; a
// border pixel also passes calc and put; an interior pixel also waits for the
// normalizer's nine-step multiply-accumulate and, if needed, eight-step divider.
// The output register lets the next request enter while a result waits.
`include "assert_macros.svh"
`default_nettype none
module conv3x3_normalized_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_pixel_in,
   input  logic                        req_flush,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_pixel_out,
   output logic                        rsp_end_of_frame,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [cnv_pkg::ADDR_W-1:0]  paddr,
   input  logic [cnv_pkg::DATA_W-1:0]  pwdata,
   output logic [cnv_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import cnv_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_CALC, ST_WAIT, ST_PUT} state_type;

   typedef struct packed {
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] pix;
      logic             has_res;
      logic             interior;
      logic             eof;
   } item_type;

   logic [TAPS_W-1:0]    taps_ff;
   logic [CFG_DIM_W-1:0] width_ff;
   logic [CFG_DIM_W-1:0] height_ff;
   logic [1:0]           reg_index;
   logic                 csr_write;

   state_type        state_ff, state_in;
   item_type         item_ff, item_in;
   window_type       win_ff, win_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0] res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] pix_out_ff, pix_out_in;
   logic             eof_out_ff, eof_out_in;

   logic [WD_W-1:0]  w_cfg, w_eff, col_ext, ocol;
   logic [HD_W-1:0]  h_cfg, h_eff, row_ext, orow;
   logic             restart, idle_flush, wrap, has_res, interior, eof;
   logic [COL_W-1:0] c_sel;
   logic [ROW_W-1:0] r_sel;
   logic [PIX_W-1:0] pix_sel;
   logic [PIX_W-1:0] up_rd, lo_rd;
   logic [COL_W-1:0] up_rd_addr;
   logic             mem_we;
   logic             norm_start;
   norm_sts_type     norm_sts;

   assign pready    = 1'b1;
   assign reg_index = paddr[ADDR_W-1:3];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff   <= TAPS_RESET;
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_TAPS:   taps_ff   <= pwdata[TAPS_W-1:0];
            REG_WIDTH:  width_ff  <= pwdata[CFG_DIM_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[CFG_DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_TAPS:   prdata = DATA_W'(taps_ff);
         REG_WIDTH:  prdata = DATA_W'(width_ff);
         REG_HEIGHT: prdata = DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   always_comb begin
      w_cfg = WD_W'(width_ff);
      h_cfg = HD_W'(height_ff);
      if (w_cfg < WD_W'(3)) begin
         w_eff = WD_W'(3);
      end else if (w_cfg > WD_W'(MAX_WIDTH)) begin
         w_eff = WD_W'(MAX_WIDTH);
      end else begin
         w_eff = w_cfg;
      end
      if (h_cfg < HD_W'(3)) begin
         h_eff = HD_W'(3);
      end else if (h_cfg > HD_W'(MAX_HEIGHT)) begin
         h_eff = HD_W'(MAX_HEIGHT);
      end else begin
         h_eff = h_cfg;
      end

      col_ext = WD_W'(col_ff);
      row_ext = HD_W'(row_ff);
      restart = (col_ext >= w_eff) || (row_ext > h_eff + 1'b1) ||
                ((row_ext == h_eff + 1'b1) && (col_ff != '0));
      c_sel   = restart ? '0 : col_ff;
      r_sel   = restart ? '0 : row_ff;
      col_ext = WD_W'(c_sel);
      row_ext = HD_W'(r_sel);

      idle_flush = req_flush && (r_sel == '0) && (c_sel == '0);
      pix_sel    = (req_flush || (row_ext >= h_eff)) ? '0 : req_pixel_in;
      wrap       = (col_ext + 1'b1) >= w_eff;
      has_res    = (r_sel >= ROW_W'(2)) || ((r_sel == ROW_W'(1)) && (c_sel != '0));
      if (c_sel == '0) begin
         orow = row_ext - HD_W'(2);
         ocol = w_eff - 1'b1;
      end else begin
         orow = row_ext - 1'b1;
         ocol = col_ext - 1'b1;
      end
      interior = (orow != '0) && (orow + HD_W'(2) <= h_eff) &&
                 (ocol != '0) && (ocol + WD_W'(2) <= w_eff);
      eof      = (orow == h_eff - 1'b1) && (ocol == w_eff - 1'b1);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      win_in       = win_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      pix_out_in   = pix_out_ff;
      eof_out_in   = eof_out_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (idle_flush) begin
                  col_in = '0;
                  row_in = '0;
               end else begin
                  item_in.addr     = c_sel;
                  item_in.pix      = pix_sel;
                  item_in.has_res  = has_res;
                  item_in.interior = interior;
                  item_in.eof      = eof;
                  if (has_res && eof) begin
                     col_in = '0;
                     row_in = '0;
                  end else if (wrap) begin
                     col_in = '0;
                     row_in = r_sel + 1'b1;
                  end else begin
                     col_in = c_sel + 1'b1;
                     row_in = r_sel;
                  end
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = up_rd;
            win_in[3] = win_ff[4];
            win_in[4] = win_ff[5];
            win_in[5] = lo_rd;
            win_in[6] = win_ff[7];
            win_in[7] = win_ff[8];
            win_in[8] = item_ff.pix;
            state_in  = item_ff.has_res ? ST_CALC : ST_IDLE;
         end
         ST_CALC: begin
            if (item_ff.interior) begin
               state_in = ST_WAIT;
            end else begin
               // At the first column the center is the last entry of the upper row.
               res_in   = (item_ff.addr == '0) ? up_rd : win_ff[4];
               state_in = ST_PUT;
            end
         end
         ST_WAIT: begin
            if (norm_sts.done) begin
               res_in   = norm_sts.result;
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               pix_out_in   = res_ff;
               eof_out_in   = item_ff.eof;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff    <= item_in;
      res_ff     <= res_in;
      pix_out_ff <= pix_out_in;
      eof_out_ff <= eof_out_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = pix_out_ff;
   assign rsp_end_of_frame = eof_out_ff;
   assign mem_we           = (state_ff == ST_READ);
   assign norm_start       = (state_ff == ST_CALC) && item_ff.interior;
   assign up_rd_addr       = (state_ff == ST_READ) ? COL_W'(w_eff - 1'b1) : c_sel;

   cnv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (item_ff.addr),
      .wr_data (lo_rd),
      .rd_addr (up_rd_addr),
      .rd_data (up_rd)
   );

   cnv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (item_ff.addr),
      .wr_data (item_ff.pix),
      .rd_addr (c_sel),
      .rd_data (lo_rd)
   );

   cnv_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .window (win_ff),
      .taps   (taps_ff),
      .sts    (norm_sts)
   );

   `CNV_ASSERT(a_done_in_wait, norm_sts.done |-> (state_ff == ST_WAIT), "normalizer done outside wait")
   `CNV_ASSERT(a_eof_clears, (state_ff == ST_READ && item_ff.has_res && item_ff.eof) |-> (col_ff == '0 && row_ff == '0), "counters not cleared at frame end")
   `CNV_ASSERT_NEXT(a_put_loads, state_ff == ST_PUT && !(rsp_valid_ff && rsp_stall), rsp_valid_ff, "result not loaded")
endmodule
`default_nettype wire
